// File: hdl/sci_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package sci_pkg;

    localparam int LineLenDefault = 32;

    typedef enum logic [1:0] {
        PH_INT  = 2'd0,
        PH_FRAC = 2'd1,
        PH_DONE = 2'd2
    } phase_t;

    typedef enum logic [1:0] {
        RC_OK      = 2'd0,
        RC_UNKNOWN = 2'd1,
        RC_BADARG  = 2'd2,
        RC_NOTRUN  = 2'd3
    } reply_t;

    localparam logic       FUNC_BYTE   = 1'b0;
    localparam logic       KIND_REPLY  = 1'b0;
    localparam logic       KIND_UPDATE = 1'b1;
    localparam logic [7:0] CH_CR       = 8'h0D;
    localparam logic [7:0] CH_MINUS    = 8'h2D;
    localparam logic [7:0] CH_DOT      = 8'h2E;
    localparam logic [7:0] CH_ZERO     = 8'h30;
    localparam logic [7:0] CMD_D       = 8'h44;
    localparam logic [7:0] CMD_I       = 8'h49;
    localparam logic [7:0] CMD_L       = 8'h4C;
    localparam logic [7:0] CMD_R       = 8'h52;
    localparam logic [7:0] CMD_S       = 8'h53;
    localparam logic [7:0] CMD_T       = 8'h54;
    localparam logic [16:0] ELAPSED_MAX = 17'd131071;

    // one result beat
    typedef struct packed {
        logic       kind;
        logic [1:0] reply_code;
        logic [7:0] motor_angle;
        logic [7:0] steering_angle;
        logic       last_of_run;
    } beat_t;

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= 8'h30) && (c <= 8'h39);
    endfunction

endpackage
`default_nettype wire

// File: hdl/sci_angles.sv
`timescale 1ns / 1ps
`default_nettype none
module sci_angles
    import sci_pkg::*;
(
    input  wire logic signed [14:0] throttle,
    input  wire logic signed [14:0] steering,
    output logic [7:0]              motor_angle,
    output logic [7:0]              steering_angle
);
    // operands are never negative: throttle >= -10000, steering >= -9000
    logic [17:0] m_num;
    logic [14:0] s_num;
    logic [36:0] m_prod;
    logic [26:0] s_prod;

    always_comb
    begin
        m_num = 18'(32'sd90000 + 32'sd9 * 32'(throttle));
        s_num = 15'(32'sd9000 + 32'(steering));
        // reciprocal multiply, exact for these ranges
        m_prod = 37'(m_num) * 37'd268436;
        s_prod = 27'(s_num) * 27'd5243;
        motor_angle    = 8'(m_prod >> 28);
        steering_angle = 8'(s_prod >> 19);
    end
endmodule
`default_nettype wire

// File: hdl/servo_command_interpreter_unit.sv
// servo command interpreter
// input channel (in_valid/in_ready): func 0 carries a received serial byte,
// func 1 a one millisecond tick. printable bytes build the command line, a
// carriage return executes it.
// output channel (out_valid/out_ready): 0 to 2 items per input item, a reply
// (kind 0) before an angle update (kind 1); last_of_run marks the final one.
// the input item updates all state in the cycle it is accepted; its results
// enter a two-entry result queue and the first one appears the next cycle.
// an item with two results holds off the next input until one has left, set
// by the single output port; items with at most one flow while out_ready.
// in_ready is low only while the queue cannot hold a further two items.
// a stalled receiver holds the queue head; the input side stops once the
// queue is too full.
// reset: no line held, timeout 1000 ms, throttle limit 5.00, not running,
// and an angle update is pending, sent after the first input item.
`timescale 1ns / 1ps
`default_nettype none
module servo_command_interpreter_unit
    import sci_pkg::*;
#(
    parameter int LINE_LEN = LineLenDefault
)
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire logic       func,
    input  wire logic [7:0] rx_byte,
    output logic            out_valid,
    input  wire logic       out_ready,
    output logic            kind,
    output logic [1:0]      reply_code,
    output logic [7:0]      motor_angle,
    output logic [7:0]      steering_angle,
    output logic            last_of_run
);
    localparam int CW = $clog2(LINE_LEN);

    logic [CW-1:0]      cnt_reg, cnt_next;
    logic [7:0]         letter_reg, letter_next;
    logic               neg_reg, neg_next, sd_reg, sd_next;
    phase_t             ph_reg, ph_next;
    logic [15:0]        ip_reg, ip_next;
    logic [6:0]         fh_reg, fh_next;
    logic [1:0]         fc_reg, fc_next;
    logic               fx_reg, fx_next;
    logic [15:0]        tmo_reg, tmo_next;
    logic [13:0]        tl_reg, tl_next;
    logic               run_reg, run_next, pend_reg, pend_next;
    logic signed [14:0] thr_reg, thr_next, str_reg, str_next;
    logic [16:0]        el_reg, el_next;

    beat_t      q_reg [2];
    beat_t      q_next [2];
    logic [1:0] qn_reg, qn_next;

    logic [7:0] m_ang, s_ang;
    sci_angles u_ang (.throttle(thr_next), .steering(str_next),
                      .motor_angle(m_ang), .steering_angle(s_ang));

    logic        acc, pop, is_cr, first, plain, upd;
    logic [20:0] ip10;
    logic [22:0] v;
    logic [6:0]  fv;
    logic [1:0]  rc;
    logic [3:0]  dig;
    beat_t       b_rep, b_upd;
    beat_t       nb [2];
    logic [1:0]  nn;

    assign in_ready  = (qn_reg == 2'd0) || (qn_reg == 2'd1 && out_ready);
    assign acc       = in_valid && in_ready;
    assign out_valid = qn_reg != 2'd0;
    assign pop       = out_valid && out_ready;
    assign kind           = q_reg[0].kind;
    assign reply_code     = q_reg[0].reply_code;
    assign motor_angle    = q_reg[0].motor_angle;
    assign steering_angle = q_reg[0].steering_angle;
    assign last_of_run    = q_reg[0].last_of_run;

    always_comb
    begin
        cnt_next = cnt_reg; letter_next = letter_reg; neg_next = neg_reg;
        sd_next = sd_reg; ph_next = ph_reg; ip_next = ip_reg; fh_next = fh_reg;
        fc_next = fc_reg; fx_next = fx_reg; tmo_next = tmo_reg; tl_next = tl_reg;
        run_next = run_reg; pend_next = pend_reg; thr_next = thr_reg;
        str_next = str_reg; el_next = el_reg;
        is_cr = 1'b0; rc = RC_OK; first = 1'b0; upd = 1'b0;
        dig = 4'(rx_byte - CH_ZERO);
        ip10 = 21'(ip_reg) * 21'd10 + 21'(dig);
        fv = (fc_reg == 2'd1) ? 7'(fh_reg * 7'd10) : fh_reg;
        v = 23'(ip_reg) * 23'd100 + 23'(fv);
        plain = sd_reg && !neg_reg;
        if (acc)
        begin
            if (func == FUNC_BYTE)
            begin
                if (rx_byte >= 8'h20 && rx_byte <= 8'h7F)
                begin
                    if (32'(cnt_reg) < LINE_LEN - 1)
                    begin
                        cnt_next = cnt_reg + 1'b1;
                        first = (cnt_reg == CW'(1)) || (cnt_reg == CW'(2) && neg_reg);
                        if (cnt_reg == '0)
                            letter_next = rx_byte;
                        else if (cnt_reg == CW'(1) && rx_byte == CH_MINUS)
                            neg_next = 1'b1;
                        else if (first && !is_digit(rx_byte))
                        begin
                            sd_next = 1'b0;
                            ph_next = PH_DONE;
                        end
                        else
                        begin
                            if (first)
                                sd_next = 1'b1;
                            case (ph_reg)
                                PH_INT:
                                    if (is_digit(rx_byte))
                                        ip_next = (ip10 > 21'd65535) ? 16'hFFFF : 16'(ip10);
                                    else if (rx_byte == CH_DOT)
                                        ph_next = PH_FRAC;
                                    else
                                        ph_next = PH_DONE;
                                PH_FRAC:
                                    if (is_digit(rx_byte))
                                    begin
                                        if (fc_reg < 2'd2)
                                        begin
                                            fh_next = 7'(fh_reg * 7'd10 + 7'(dig));
                                            fc_next = fc_reg + 2'd1;
                                        end
                                        else if (rx_byte != CH_ZERO)
                                            fx_next = 1'b1;
                                    end
                                    else
                                        ph_next = PH_DONE;
                                default: ;
                            endcase
                        end
                    end
                end
                else if (rx_byte == CH_CR)
                begin
                    is_cr = 1'b1;
                    case (letter_reg)
                        CMD_D:
                            if (!plain) rc = RC_BADARG;
                            else tmo_next = ip_reg;
                        CMD_I: rc = RC_OK;
                        CMD_L:
                            if (!plain || v > 23'd10000 || (v == 23'd10000 && fx_reg))
                                rc = RC_BADARG;
                            else tl_next = 14'(v);
                        CMD_R:
                        begin
                            run_next = 1'b1; thr_next = '0; str_next = '0;
                            pend_next = 1'b1; el_next = '0;
                        end
                        CMD_S:
                            if (!sd_reg || v > 23'd9000 || (v == 23'd9000 && fx_reg))
                                rc = RC_BADARG;
                            else if (!run_reg) rc = RC_NOTRUN;
                            else
                            begin
                                str_next = neg_reg ? -15'(v) : 15'(v);
                                pend_next = 1'b1;
                            end
                        CMD_T:
                            if (!sd_reg || v > 23'd10000 || (v == 23'd10000 && fx_reg))
                                rc = RC_BADARG;
                            else if (!run_reg) rc = RC_NOTRUN;
                            else
                            begin
                                if (v > 23'(tl_reg))
                                    thr_next = neg_reg ? -15'(tl_reg) : 15'(tl_reg);
                                else
                                    thr_next = neg_reg ? -15'(v) : 15'(v);
                                pend_next = 1'b1; el_next = '0;
                            end
                        default: rc = RC_UNKNOWN;
                    endcase
                    cnt_next = '0; letter_next = '0; neg_next = 1'b0; sd_next = 1'b0;
                    ph_next = PH_INT; ip_next = '0; fh_next = '0; fc_next = '0;
                    fx_next = 1'b0;
                end
            end
            else if (el_reg < ELAPSED_MAX)
                el_next = el_reg + 17'd1;
            if (el_next > 17'(tmo_next))
            begin
                run_next = 1'b0; thr_next = '0; pend_next = 1'b1;
            end
            // a pending update leaves with this item
            upd = pend_next;
            pend_next = 1'b0;
        end
    end

    // results of the current item and queue update
    always_comb
    begin
        b_rep = '{kind: KIND_REPLY, reply_code: rc, motor_angle: 8'd0,
                  steering_angle: 8'd0, last_of_run: !upd};
        b_upd = '{kind: KIND_UPDATE, reply_code: RC_OK, motor_angle: m_ang,
                  steering_angle: s_ang, last_of_run: 1'b1};
        nb[0] = is_cr ? b_rep : b_upd;
        nb[1] = b_upd;
        nn = (acc && is_cr ? 2'd1 : 2'd0) + (upd ? 2'd1 : 2'd0);
        q_next[0] = q_reg[0];
        q_next[1] = q_reg[1];
        qn_next = qn_reg;
        if (pop)
        begin
            q_next[0] = q_reg[1];
            qn_next = qn_reg - 2'd1;
        end
        if (nn != 2'd0)
        begin
            if (qn_next == 2'd0)
            begin
                q_next[0] = nb[0];
                q_next[1] = nb[1];
            end
            else
                q_next[1] = nb[0];
            qn_next = qn_next + nn;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0; letter_reg <= '0; neg_reg <= 1'b0; sd_reg <= 1'b0;
            ph_reg <= PH_INT; ip_reg <= '0; fh_reg <= '0; fc_reg <= '0;
            fx_reg <= 1'b0; tmo_reg <= 16'd1000; tl_reg <= 14'd500;
            run_reg <= 1'b0; pend_reg <= 1'b1; thr_reg <= '0; str_reg <= '0;
            el_reg <= '0; qn_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next; letter_reg <= letter_next; neg_reg <= neg_next;
            sd_reg <= sd_next; ph_reg <= ph_next; ip_reg <= ip_next;
            fh_reg <= fh_next; fc_reg <= fc_next; fx_reg <= fx_next;
            tmo_reg <= tmo_next; tl_reg <= tl_next; run_reg <= run_next;
            pend_reg <= pend_next; thr_reg <= thr_next; str_reg <= str_next;
            el_reg <= el_next; qn_reg <= qn_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg[0] <= q_next[0];
        q_reg[1] <= q_next[1];
    end
endmodule
`default_nettype wire

// File: tb/sv/tb_top.sv
`timescale 1ns / 1ps
module tb_top;
    import sci_pkg::*;

    localparam int LINE_CAP = LineLenDefault - 1;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_ready;
    logic       func = 1'b0;
    logic [7:0] rx_byte = 8'h00;
    logic       out_valid;
    logic       out_ready = 1'b0;
    logic       kind;
    logic [1:0] reply_code;
    logic [7:0] motor_angle;
    logic [7:0] steering_angle;
    logic       last_of_run;

    servo_command_interpreter_unit i_dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .func(func), .rx_byte(rx_byte),
        .out_valid(out_valid), .out_ready(out_ready),
        .kind(kind), .reply_code(reply_code),
        .motor_angle(motor_angle), .steering_angle(steering_angle),
        .last_of_run(last_of_run)
    );

    always #5 clk = ~clk;

    // predictor state
    int unsigned n_chars;
    logic [7:0]  letter;
    bit          neg;
    bit          starts_digit;
    phase_t      phase;
    int unsigned ipart;
    int unsigned fpart;
    int unsigned fdigits;
    bit          fextra;
    int unsigned timeout_ms;
    int unsigned thr_limit;
    bit          is_running;
    int          throttle;
    int          steering;
    int unsigned elapsed;
    bit          angles_due;

    beat_t expected_beats[$];
    int    errors = 0;
    int    n_replies = 0;
    int    n_updates = 0;
    int    n_items = 0;
    bit    quiet_mode = 1'b0;

    function automatic bit digit(input logic [7:0] c);
        return c >= 8'h30 && c <= 8'h39;
    endfunction

    function automatic void reset_line();
        n_chars = 0; letter = 8'h00; neg = 0; starts_digit = 0; phase = PH_INT;
        ipart = 0; fpart = 0; fdigits = 0; fextra = 0;
    endfunction

    function automatic void reset_predictor();
        reset_line();
        timeout_ms = 1000; thr_limit = 500; is_running = 0;
        throttle = 0; steering = 0; elapsed = 0; angles_due = 1;
    endfunction

    function automatic void parse_number(input logic [7:0] c);
        if (phase == PH_INT) begin
            if (digit(c)) begin
                ipart = ipart * 10 + (c - CH_ZERO);
                if (ipart > 65535) ipart = 65535;
            end
            else if (c == CH_DOT) phase = PH_FRAC;
            else phase = PH_DONE;
        end
        else if (phase == PH_FRAC) begin
            if (digit(c)) begin
                if (fdigits < 2) begin
                    fpart = fpart * 10 + (c - CH_ZERO);
                    fdigits++;
                end
                else if (c != CH_ZERO) fextra = 1;
            end
            else phase = PH_DONE;
        end
    endfunction

    function automatic void append_char(input logic [7:0] c);
        bit first;
        if (n_chars == 0) begin
            letter = c;
            return;
        end
        if (n_chars == 1 && c == CH_MINUS) begin
            neg = 1;
            return;
        end
        first = (n_chars == 1) || (n_chars == 2 && neg);
        if (first) begin
            starts_digit = digit(c);
            if (!starts_digit) begin
                phase = PH_DONE;
                return;
            end
        end
        parse_number(c);
    endfunction

    function automatic bit over(input int unsigned v, input int unsigned bound);
        return v > bound || (v == bound && fextra);
    endfunction

    function automatic reply_t execute_line();
        int unsigned v;
        v = ipart * 100 + ((fdigits == 1) ? fpart * 10 : fpart);
        case (letter)
            CMD_D: begin
                if (!(starts_digit && !neg)) return RC_BADARG;
                timeout_ms = ipart;
                return RC_OK;
            end
            CMD_I: return RC_OK;
            CMD_L: begin
                if (!(starts_digit && !neg) || over(v, 10000)) return RC_BADARG;
                thr_limit = v;
                return RC_OK;
            end
            CMD_R: begin
                is_running = 1; throttle = 0; steering = 0;
                angles_due = 1; elapsed = 0;
                return RC_OK;
            end
            CMD_S: begin
                if (!starts_digit || over(v, 9000)) return RC_BADARG;
                if (!is_running) return RC_NOTRUN;
                steering = neg ? -int'(v) : int'(v);
                angles_due = 1;
                return RC_OK;
            end
            CMD_T: begin
                if (!starts_digit || over(v, 10000)) return RC_BADARG;
                if (v > thr_limit) v = thr_limit;
                if (!is_running) return RC_NOTRUN;
                throttle = neg ? -int'(v) : int'(v);
                angles_due = 1; elapsed = 0;
                return RC_OK;
            end
            default: return RC_UNKNOWN;
        endcase
    endfunction

    function automatic void predict_item(input logic f, input logic [7:0] c);
        beat_t b;
        beat_t outs[$];
        int    m;
        int    s;
        if (f == FUNC_BYTE) begin
            if (c >= 8'h20 && c <= 8'h7F) begin
                if (n_chars < LINE_CAP) begin
                    append_char(c);
                    n_chars++;
                end
            end
            else if (c == CH_CR) begin
                b = '0;
                b.kind = KIND_REPLY;
                b.reply_code = execute_line();
                outs.push_back(b);
                reset_line();
            end
        end
        else if (elapsed < ELAPSED_MAX) elapsed++;
        if (elapsed > timeout_ms) begin
            is_running = 0; throttle = 0; angles_due = 1;
        end
        if (angles_due) begin
            m = (90000 + 9 * throttle) / 1000;
            s = (9000 + steering) / 100;
            if (m < 0) m = 0;
            if (m > 180) m = 180;
            if (s < 0) s = 0;
            if (s > 180) s = 180;
            b = '0;
            b.kind = KIND_UPDATE;
            b.motor_angle = m[7:0];
            b.steering_angle = s[7:0];
            outs.push_back(b);
            angles_due = 0;
        end
        if (outs.size() > 0) outs[outs.size() - 1].last_of_run = 1'b1;
        foreach (outs[i]) expected_beats.push_back(outs[i]);
    endfunction

    // valid stays up between back to back items and drops only for a gap
    task automatic send_item(input logic f, input logic [7:0] c);
        int gap;
        if (!quiet_mode && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 17);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        func <= f;
        rx_byte <= c;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        predict_item(f, c);
        n_items++;
    endtask

    task automatic send_line(input string text);
        for (int i = 0; i < text.len(); i++) send_item(FUNC_BYTE, text[i]);
        send_item(FUNC_BYTE, CH_CR);
    endtask

    task automatic send_ticks(input int count);
        repeat (count) send_item(1'b1, 8'h00);
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (expected_beats.size() > 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // receiver side: random stall bursts, none in the quiet part
    initial begin
        int stall;
        @(posedge rst_n);
        forever begin
            if (!quiet_mode && $urandom_range(0, 4) == 0) begin
                out_ready <= 1'b0;
                stall = $urandom_range(1, 17);
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            @(posedge clk);
        end
    end

    always @(posedge clk) begin
        beat_t want;
        if (rst_n && out_valid && out_ready) begin
            if (expected_beats.size() == 0) begin
                $display("%0t: unexpected item kind=%0d code=%0d motor=%0d steer=%0d last=%0d",
                    $time, kind, reply_code, motor_angle, steering_angle, last_of_run);
                errors++;
            end
            else begin
                want = expected_beats.pop_front();
                if (kind == KIND_REPLY) n_replies++;
                else n_updates++;
                if (want != {kind, reply_code, motor_angle, steering_angle, last_of_run}) begin
                    $display("%0t: mismatch expected kind=%0d code=%0d motor=%0d steer=%0d last=%0d",
                        $time, want.kind, want.reply_code, want.motor_angle,
                        want.steering_angle, want.last_of_run);
                    $display("%0t:          actual kind=%0d code=%0d motor=%0d steer=%0d last=%0d",
                        $time, kind, reply_code, motor_angle, steering_angle, last_of_run);
                    errors++;
                end
            end
        end
    end

    task automatic test_commands();
        send_line("");
        send_line("I");
        send_line("X12");
        send_line("S10");
        send_line("T-50");
        send_line("R");
        send_line("S-90");
        send_line("S90.001");
        send_line("S 5");
        send_line("L100");
        send_line("L100.5");
        send_line("L-3");
        send_line("T100");
        send_line("T-100.009");
        send_line("T7.5x");
        send_line("D99999");
        send_line("D-1");
        send_line("L37.25");
        send_line("T99");
        send_line("S45.678");
        send_line("Tabc");
        send_item(FUNC_BYTE, 8'hFF);
        send_item(FUNC_BYTE, 8'h0A);
        send_line("IIIIIIIIIIIIIIIIIIIIIIIIIIIIIIIIIIIIIIII");
    endtask

    task automatic test_timeout();
        send_line("D3");
        send_line("R");
        send_line("T50");
        send_ticks(6);
        send_line("S20");
        send_line("D1000");
        // hold off until the block has caught up
        wait_drained();
        send_line("R");
    endtask

    function automatic logic [7:0] pick_char();
        case ($urandom_range(0, 9))
            0: return CH_MINUS;
            1: return CH_DOT;
            2: return 8'($urandom_range(8'h20, 8'h7F));
            default: return 8'($urandom_range(8'h30, 8'h39));
        endcase
    endfunction

    task automatic test_random(input int budget);
        int start;
        int len;
        logic [7:0] cmds[7];
        cmds = '{CMD_D, CMD_I, CMD_L, CMD_R, CMD_S, CMD_T, 8'h51};
        start = n_items;
        while (n_items - start < budget) begin
            case ($urandom_range(0, 9))
                0: send_ticks($urandom_range(1, 40));
                1: send_item(FUNC_BYTE, 8'($urandom));
                default: begin
                    send_item(FUNC_BYTE, cmds[$urandom_range(0, 6)]);
                    if ($urandom_range(0, 2) == 0) send_item(FUNC_BYTE, CH_MINUS);
                    len = $urandom_range(0, 7);
                    repeat (len) send_item(FUNC_BYTE, pick_char());
                    send_item(FUNC_BYTE, CH_CR);
                end
            endcase
        end
    endtask

    initial begin
        reset_predictor();
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_commands();
        test_timeout();
        test_random(850);
        quiet_mode = 1'b1;
        test_random(150);
        wait_drained();
        repeat (20) @(posedge clk);
        $display("%0d items sent, %0d replies and %0d angle updates checked",
            n_items, n_replies, n_updates);
        if (errors == 0 && expected_beats.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    initial begin
        #5ms;
        $display("CHECK FAILED");
        $finish;
    end
endmodule

// File: filelist.f
hdl/sci_pkg.sv
hdl/sci_angles.sv
hdl/servo_command_interpreter_unit.sv
tb/sv/tb_top.sv
